// ===== sv/chain_dominance_judge_assert.svh =====
// Assertion macros shared by the chain dominance judge.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CHAIN_DOMINANCE_JUDGE_ASSERT_SVH
`define CHAIN_DOMINANCE_JUDGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDJ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdj assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CDJ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdj assertion failed");

`endif

// ===== sv/cdj_pkg.sv =====
// Shared constants, types and helpers of the chain dominance judge.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cdj_pkg;

    localparam int MAX_CHAINS = 256;
    localparam int CNT_W      = $clog2(MAX_CHAINS);
    localparam int WIDE_W     = CNT_W + 8;

    localparam int CFG_W      = 17;
    localparam int COVF_W     = 17;
    localparam int DOMR_W     = 16;

    localparam logic [0:0] CFG_COVERAGE_FRACTION = 1'd0;
    localparam logic [0:0] CFG_DOMINANCE_RATIO   = 1'd1;

    localparam logic [COVF_W-1:0] COVF_RESET = 17'd58982;
    localparam logic [DOMR_W-1:0] DOMR_RESET = 16'd512;

    localparam logic [2:0] V_DOMINANT  = 3'd0;
    localparam logic [2:0] V_NO_CHAINS = 3'd1;
    localparam logic [2:0] V_NO_LENGTH = 3'd2;
    localparam logic [2:0] V_INTRON    = 3'd3;
    localparam logic [2:0] V_PARTIAL   = 3'd4;
    localparam logic [2:0] V_COMPETING = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the input word into the per-read state
        logic mult;     // form the coverage and dominance products
        logic judge;    // load the verdict register and clear the read
    } cdj_cmd_t;

    // Chain index clipped to the 8-bit result field.
    function automatic logic [7:0] sat_winner(input logic [CNT_W-1:0] idx);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(idx);
        if (wide > WIDE_W'(255))
            return 8'd255;
        return wide[7:0];
    endfunction

endpackage

// ===== sv/cdj_ctrl.sv =====
// Controller of the chain dominance judge: sequences a verdict after the
// last word of a read and owns the output valid flag. Depends on cdj_pkg.
`timescale 1ns / 1ps

module cdj_ctrl
    import cdj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     last_chain,
    input  logic     out_stall,
    output logic     in_stall,
    output logic     out_valid,
    output cdj_cmd_t cmd
);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_MULT   = 2'd1;
    localparam logic [1:0] ST_JUDGE  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && last_chain)
                    state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_JUDGE;
            end
            ST_JUDGE:
            begin
                // The verdict waits here until the output register is free.
                if (out_free)
                begin
                    cmd.judge      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/cdj_dp.sv =====
// Datapath of the chain dominance judge: per-read best and runner-up state,
// configuration registers, products and the verdict register. Uses cdj_pkg.
`timescale 1ns / 1ps

module cdj_dp
    import cdj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cdj_cmd_t           cmd,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               chain_present,
    input  logic signed [31:0] chain_score,
    input  logic [31:0]        span_begin,
    input  logic [31:0]        span_end,
    input  logic               intron_gap,
    input  logic [31:0]        read_length,
    output logic               is_resolved,
    output logic [7:0]         winner_index,
    output logic [2:0]         verdict_code
);

    logic [COVF_W-1:0]  cov_frac_reg;
    logic [DOMR_W-1:0]  dom_ratio_reg;

    logic signed [31:0] top_score_reg, top_score_next;
    logic [CNT_W-1:0]   top_index_reg, top_index_next;
    logic [31:0]        top_covered_reg, top_covered_next;
    logic               top_intron_reg, top_intron_next;
    logic signed [31:0] runner_score_reg, runner_score_next;
    logic               runner_valid_reg, runner_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        rlen_reg;

    logic [48:0]        cov_prod_reg;
    logic signed [48:0] dom_prod_reg;

    logic               is_resolved_reg;
    logic [7:0]         winner_index_reg;
    logic [2:0]         verdict_code_reg;

    logic [31:0]        span_len;
    logic [48:0]        cov_lhs;
    logic signed [48:0] dom_lhs;
    logic [2:0]         verdict;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cov_frac_reg  <= COVF_RESET;
            dom_ratio_reg <= DOMR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COVERAGE_FRACTION: cov_frac_reg  <= cfg_data;
                CFG_DOMINANCE_RATIO:   dom_ratio_reg <= cfg_data[DOMR_W-1:0];
                default:               ;
            endcase
        end
    end

    assign span_len = (span_end > span_begin) ? (span_end - span_begin) : 32'd0;

    // Best and runner-up tracking; a tie never displaces the best chain.
    always_comb
    begin
        top_score_next    = top_score_reg;
        top_index_next    = top_index_reg;
        top_covered_next  = top_covered_reg;
        top_intron_next   = top_intron_reg;
        runner_score_next = runner_score_reg;
        runner_valid_next = runner_valid_reg;
        count_next        = count_reg;
        if (cmd.judge)
        begin
            top_score_next    = '0;
            top_index_next    = '0;
            top_covered_next  = '0;
            top_intron_next   = 1'b0;
            runner_score_next = '0;
            runner_valid_next = 1'b0;
            count_next        = '0;
        end
        else if (cmd.accept && chain_present)
        begin
            if (count_reg == '0)
            begin
                top_score_next   = chain_score;
                top_index_next   = '0;
                top_covered_next = span_len;
                top_intron_next  = intron_gap;
            end
            else if (chain_score > top_score_reg)
            begin
                runner_score_next = top_score_reg;
                runner_valid_next = 1'b1;
                top_score_next    = chain_score;
                top_index_next    = count_reg;
                top_covered_next  = span_len;
                top_intron_next   = intron_gap;
            end
            else if (!runner_valid_reg || chain_score > runner_score_reg)
            begin
                runner_score_next = chain_score;
                runner_valid_next = 1'b1;
            end
            if (count_reg < CNT_W'(MAX_CHAINS - 1))
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_score_reg    <= '0;
            top_index_reg    <= '0;
            top_covered_reg  <= '0;
            top_intron_reg   <= 1'b0;
            runner_score_reg <= '0;
            runner_valid_reg <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            top_score_reg    <= top_score_next;
            top_index_reg    <= top_index_next;
            top_covered_reg  <= top_covered_next;
            top_intron_reg   <= top_intron_next;
            runner_score_reg <= runner_score_next;
            runner_valid_reg <= runner_valid_next;
            count_reg        <= count_next;
        end
    end

    // Read length and the two cross-multiply products.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rlen_reg <= read_length;
        if (cmd.mult)
        begin
            cov_prod_reg <= 49'(rlen_reg) * 49'(cov_frac_reg);
            dom_prod_reg <= $signed({1'b0, dom_ratio_reg}) * runner_score_reg;
        end
    end

    assign cov_lhs = {1'b0, top_covered_reg, 16'd0};
    assign dom_lhs = 49'($signed({top_score_reg, 8'd0}));

    always_comb
    begin
        if (count_reg == '0)
            verdict = V_NO_CHAINS;
        else if (rlen_reg == 32'd0)
            verdict = V_NO_LENGTH;
        else if (top_intron_reg)
            verdict = V_INTRON;
        else if (cov_lhs < cov_prod_reg)
            verdict = V_PARTIAL;
        else if (runner_valid_reg && runner_score_reg > 32'sd0 && dom_lhs < dom_prod_reg)
            verdict = V_COMPETING;
        else
            verdict = V_DOMINANT;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.judge)
        begin
            verdict_code_reg <= verdict;
            is_resolved_reg  <= (verdict == V_DOMINANT);
            winner_index_reg <= (verdict == V_DOMINANT) ? sat_winner(top_index_reg) : 8'd0;
        end
    end

    assign is_resolved  = is_resolved_reg;
    assign winner_index = winner_index_reg;
    assign verdict_code = verdict_code_reg;

endmodule

// ===== sv/chain_dominance_judge.sv =====
// Chain dominance judge top level: controller plus datapath.
// Depends on cdj_pkg, cdj_ctrl, cdj_dp and chain_dominance_judge_assert.svh.
//
//   channel   handshake             words
//   in        in_valid / in_stall   one chain summary per word
//   out       out_valid / out_stall one verdict per read
//   cfg       cfg_we                coverage_fraction, dominance_ratio
//
// A word without last_chain is taken back to back, with no stall.
// A last word is followed by the product state and then the verdict state,
// and input stalls during both; the verdict step loads the output register.
// If the previous verdict is still held, the verdict step waits until it is
// taken. Reset clears the per-read state and restores the register defaults.
`timescale 1ns / 1ps
`include "chain_dominance_judge_assert.svh"

module chain_dominance_judge
    import cdj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               chain_present,
    input  logic signed [31:0] chain_score,
    input  logic [31:0]        span_begin,
    input  logic [31:0]        span_end,
    input  logic               intron_gap,
    input  logic [31:0]        read_length,
    input  logic               last_chain,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_resolved,
    output logic [7:0]         winner_index,
    output logic [2:0]         verdict_code
);

    cdj_cmd_t cmd;

    cdj_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_chain (last_chain),
        .out_stall  (out_stall),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    cdj_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .chain_present (chain_present),
        .chain_score   (chain_score),
        .span_begin    (span_begin),
        .span_end      (span_end),
        .intron_gap    (intron_gap),
        .read_length   (read_length),
        .is_resolved   (is_resolved),
        .winner_index  (winner_index),
        .verdict_code  (verdict_code)
    );

    `CDJ_ASSERT_NEXT(a_last_word_blocks, in_valid && !in_stall && last_chain, in_stall)
    `CDJ_ASSERT_NOW(a_resolved_matches, out_valid, is_resolved == (verdict_code == V_DOMINANT))
    `CDJ_ASSERT_NOW(a_index_zero, out_valid && verdict_code != V_DOMINANT, winner_index == 8'd0)
    `CDJ_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.accept, cmd.mult, cmd.judge}))

endmodule
